@@ rtl/cbal_pkg.sv @@
// Package for the cubic Bezier evaluator and chord-length block.
// Holds the opcodes, controller states and the command bundle. No dependencies.
package cbal_pkg;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_EVAL = 2'd1,
        OP_LEN  = 2'd2,
        OP_NONE = 2'd3
    } cbal_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COEF_C,
        ST_COEF_B,
        ST_COEF_A,
        ST_HINIT,
        ST_MUL,
        ST_ACC,
        ST_SAT,
        ST_SQ_DIFF,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_ROOT_INIT,
        ST_SQRT,
        ST_CHORD,
        ST_DONE
    } cbal_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       start_eval;
        logic       start_len;
        logic       coef_c;
        logic       coef_b;
        logic       coef_a;
        logic       hinit;
        logic       mul;
        logic       acc;
        logic       sat;
        logic       advance;
        logic       sq_diff;
        logic       sq_mul;
        logic       sq_add;
        logic       root_init;
        logic       sqrt_step;
        logic       chord;
        logic       emit;
        logic       len_mode;
        logic [1:0] axis;
        logic [1:0] step;
    } cbal_cmd_t;

    localparam int unsigned ONE_Q16 = 65536;
    localparam int unsigned SQRT_STEPS = 32;

endpackage

@@ rtl/cbal_if.sv @@
// Request and response channel interfaces of the Bezier block.
// Depends on nothing; valid/ready handshake with the payload fields.
interface cbal_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [1:0]         point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [16:0]        curve_param;

    modport source (output valid, op, point_index, coord_x, coord_y, coord_z, curve_param,
                    input ready);
    modport sink (input valid, op, point_index, coord_x, coord_y, coord_z, curve_param,
                  output ready);
endinterface

interface cbal_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        arc_length;

    modport source (output valid, pos_x, pos_y, pos_z, arc_length, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, arc_length, output ready);
endinterface

@@ rtl/cbal_ctrl.sv @@
// Controller state machine of the Bezier block: sequencing, loop counters, handshakes.
// Depends on cbal_pkg.
module cbal_ctrl
    import cbal_pkg::*;
#(
    parameter int unsigned SEGMENTS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic [1:0] op,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output cbal_cmd_t cmd
);

    localparam int unsigned KW = $clog2(SEGMENTS + 1);
    localparam logic [KW-1:0] K_LAST = KW'(SEGMENTS);
    localparam logic [4:0] ITER_LAST = 5'(SQRT_STEPS - 1);

    cbal_state_t   state_reg, state_next;
    logic [1:0]    axis_reg, axis_next;
    logic [1:0]    step_reg, step_next;
    logic [KW-1:0] k_reg, k_next;
    logic [4:0]    iter_reg, iter_next;
    logic          len_reg, len_next;
    logic          out_valid_reg, out_valid_next;
    logic          start;
    logic          out_free;

    assign start    = (state_reg == ST_IDLE) && in_valid
                      && ((op == OP_EVAL) || (op == OP_LEN));
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (start) state_next = ST_COEF_C;
            ST_COEF_C:    state_next = ST_COEF_B;
            ST_COEF_B:    state_next = ST_COEF_A;
            ST_COEF_A:    state_next = ST_HINIT;
            ST_HINIT:     state_next = ST_MUL;
            ST_MUL:       state_next = ST_ACC;
            ST_ACC:       state_next = (step_reg == 2'd2) ? ST_SAT : ST_MUL;
            ST_SAT:
            begin
                if (axis_reg != 2'd2)
                    state_next = ST_HINIT;
                else if (!len_reg)
                    state_next = ST_DONE;
                else if (k_reg == '0)
                    state_next = ST_HINIT;
                else
                    state_next = ST_SQ_DIFF;
            end
            ST_SQ_DIFF:   state_next = ST_SQ_MUL;
            ST_SQ_MUL:    state_next = ST_SQ_ADD;
            ST_SQ_ADD:    state_next = (axis_reg == 2'd2) ? ST_ROOT_INIT : ST_SQ_DIFF;
            ST_ROOT_INIT: state_next = ST_SQRT;
            ST_SQRT:      if (iter_reg == ITER_LAST) state_next = ST_CHORD;
            ST_CHORD:     state_next = (k_reg == K_LAST) ? ST_DONE : ST_HINIT;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.axis       = axis_reg;
        cmd.step       = step_reg;
        cmd.len_mode   = len_reg;
        cmd.load       = (state_reg == ST_IDLE) && in_valid && (op == OP_LOAD);
        cmd.start_eval = start && (op == OP_EVAL);
        cmd.start_len  = start && (op == OP_LEN);
        cmd.coef_c     = (state_reg == ST_COEF_C);
        cmd.coef_b     = (state_reg == ST_COEF_B);
        cmd.coef_a     = (state_reg == ST_COEF_A);
        cmd.hinit      = (state_reg == ST_HINIT);
        cmd.mul        = (state_reg == ST_MUL);
        cmd.acc        = (state_reg == ST_ACC);
        cmd.sat        = (state_reg == ST_SAT);
        // The first sample only seeds the previous point; later samples do so after the chord.
        // The last chord needs no further sample.
        cmd.advance    = ((state_reg == ST_SAT) && (axis_reg == 2'd2) && len_reg
                          && (k_reg == '0))
                         || ((state_reg == ST_CHORD) && (k_reg != K_LAST));
        cmd.sq_diff    = (state_reg == ST_SQ_DIFF);
        cmd.sq_mul     = (state_reg == ST_SQ_MUL);
        cmd.sq_add     = (state_reg == ST_SQ_ADD);
        cmd.root_init  = (state_reg == ST_ROOT_INIT);
        cmd.sqrt_step  = (state_reg == ST_SQRT);
        cmd.chord      = (state_reg == ST_CHORD);
        cmd.emit       = (state_reg == ST_DONE) && out_free;
    end

    always_comb
    begin
        axis_next      = axis_reg;
        step_next      = step_reg;
        k_next         = k_reg;
        iter_next      = iter_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (cmd.emit)
            out_valid_next = 1'b1;
        if (start)
        begin
            len_next  = (op == OP_LEN);
            axis_next = 2'd0;
            step_next = 2'd0;
            k_next    = '0;
            iter_next = '0;
        end
        if (cmd.acc)
            step_next = (step_reg == 2'd2) ? 2'd0 : step_reg + 2'd1;
        if (cmd.sat || cmd.sq_add)
            axis_next = (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
        if (cmd.sqrt_step)
            iter_next = iter_reg + 5'd1;
        if (cmd.advance)
            k_next = k_reg + KW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 2'd0;
            step_reg      <= 2'd0;
            k_reg         <= '0;
            iter_reg      <= '0;
            len_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            step_reg      <= step_next;
            k_reg         <= k_next;
            iter_reg      <= iter_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result emitted over an unread result");
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= K_LAST)
        else $error("sample counter beyond segment count");
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg != 2'd3)
        else $error("axis counter out of range");
    a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT && iter_reg == ITER_LAST) |=> state_reg == ST_CHORD)
        else $error("square root did not finish after its last step");
`endif

endmodule

@@ rtl/cbal_datapath.sv @@
// Datapath of the Bezier block: control points, coefficients, Horner unit,
// squaring, bit-pair square root and chord accumulator. Depends on cbal_pkg.
module cbal_datapath
    import cbal_pkg::*;
#(
    parameter int unsigned SEGMENTS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cbal_cmd_t          cmd,
    input  logic [1:0]         point_index,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [16:0]        curve_param,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic [31:0]        arc_length
);

    localparam int unsigned RW     = $clog2(SEGMENTS + 1);
    localparam logic [16:0] STEP_Q = 17'(ONE_Q16 / SEGMENTS);
    localparam logic [RW:0] STEP_R = (RW + 1)'(ONE_Q16 % SEGMENTS);
    localparam logic [RW:0] HALF   = (RW + 1)'(SEGMENTS / 2);
    localparam logic [RW:0] SEG    = (RW + 1)'(SEGMENTS);

    logic signed [31:0] pts_reg [12];
    logic signed [39:0] c_reg [3];
    logic signed [39:0] b_reg [3];
    logic signed [39:0] a_reg [3];
    logic signed [39:0] c_calc [3];
    logic signed [39:0] b_calc [3];
    logic signed [39:0] a_calc [3];
    logic signed [39:0] h_reg, h_next, addend;
    logic signed [57:0] prod_reg, rnd;
    logic signed [17:0] t_s;
    logic [16:0]        t_reg;
    logic [RW:0]        rem_reg, rem_sum;
    logic signed [31:0] cur_reg [3];
    logic signed [31:0] prev_reg [3];
    logic signed [31:0] sat_val;
    logic signed [32:0] dif;
    logic [31:0]        mag_reg;
    logic [63:0]        sqp_reg;
    logic [65:0]        sqacc_reg;
    logic [63:0]        rv_reg, res_reg, bit_reg, trial;
    logic [32:0]        tot;
    logic [31:0]        total_reg;
    logic               over_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [31:0]        arc_reg;

    // Per-axis coefficient lanes; each register stage adds one term.
    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            c_calc[ax] = ((40'(pts_reg[3 + ax]) - 40'(pts_reg[ax])) <<< 1)
                         + (40'(pts_reg[3 + ax]) - 40'(pts_reg[ax]));
            b_calc[ax] = ((40'(pts_reg[6 + ax]) - 40'(pts_reg[3 + ax])) <<< 1)
                         + (40'(pts_reg[6 + ax]) - 40'(pts_reg[3 + ax])) - c_reg[ax];
            a_calc[ax] = 40'(pts_reg[9 + ax]) - 40'(pts_reg[ax]) - c_reg[ax] - b_reg[ax];
        end
    end

    always_comb
    begin
        unique case (cmd.step)
            2'd0:    addend = b_reg[cmd.axis];
            2'd1:    addend = c_reg[cmd.axis];
            default: addend = 40'(pts_reg[cmd.axis]);
        endcase
        t_s    = $signed({1'b0, t_reg});
        // Rounding half up is a floor after adding one half.
        rnd    = (prod_reg + 58'sd32768) >>> 16;
        h_next = 40'(rnd) + addend;
        if (h_reg > 40'sd2147483647)
            sat_val = 32'sh7FFFFFFF;
        else if (h_reg < -40'sd2147483648)
            sat_val = 32'sh80000000;
        else
            sat_val = h_reg[31:0];
        dif     = 33'(cur_reg[cmd.axis]) - 33'(prev_reg[cmd.axis]);
        trial   = res_reg + bit_reg;
        rem_sum = rem_reg + STEP_R;
        tot     = {1'b0, total_reg} + {1'b0, res_reg[31:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 12; i++)
                pts_reg[i] <= '0;
        end
        else if (cmd.load)
        begin
            pts_reg[{point_index, 2'b00} - {2'b00, point_index}]         <= coord_x;
            pts_reg[{point_index, 2'b00} - {2'b00, point_index} + 4'd1] <= coord_y;
            pts_reg[{point_index, 2'b00} - {2'b00, point_index} + 4'd2] <= coord_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_eval)
            t_reg <= (curve_param > 17'(ONE_Q16)) ? 17'(ONE_Q16) : curve_param;
        if (cmd.start_len)
        begin
            t_reg     <= '0;
            rem_reg   <= HALF;
            total_reg <= '0;
            over_reg  <= 1'b0;
            sqacc_reg <= '0;
        end
        for (int ax = 0; ax < 3; ax++)
        begin
            if (cmd.coef_c)
                c_reg[ax] <= c_calc[ax];
            if (cmd.coef_b)
                b_reg[ax] <= b_calc[ax];
            if (cmd.coef_a)
                a_reg[ax] <= a_calc[ax];
        end
        if (cmd.hinit)
            h_reg <= a_reg[cmd.axis];
        if (cmd.mul)
            prod_reg <= h_reg * t_s;
        if (cmd.acc)
            h_reg <= h_next;
        if (cmd.sat)
            cur_reg[cmd.axis] <= sat_val;
        if (cmd.advance)
        begin
            // The first sample seeds in the same cycle as its last axis is saturated.
            for (int ax = 0; ax < 3; ax++)
                prev_reg[ax] <= (cmd.sat && (cmd.axis == 2'(ax))) ? sat_val : cur_reg[ax];
            // Next sample parameter: quotient and remainder of a running division.
            if (rem_sum >= SEG)
            begin
                rem_reg <= rem_sum - SEG;
                t_reg   <= t_reg + STEP_Q + 17'd1;
            end
            else
            begin
                rem_reg <= rem_sum;
                t_reg   <= t_reg + STEP_Q;
            end
        end
        if (cmd.sq_diff)
            mag_reg <= dif[32] ? 32'(-dif) : dif[31:0];
        if (cmd.sq_mul)
            sqp_reg <= mag_reg * mag_reg;
        if (cmd.sq_add)
            sqacc_reg <= sqacc_reg + 66'(sqp_reg);
        if (cmd.root_init)
        begin
            rv_reg    <= sqacc_reg[63:0];
            over_reg  <= over_reg | (|sqacc_reg[65:64]);
            res_reg   <= '0;
            bit_reg   <= 64'h4000_0000_0000_0000;
            sqacc_reg <= '0;
        end
        if (cmd.sqrt_step)
        begin
            if (rv_reg >= trial)
            begin
                rv_reg  <= rv_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.chord)
        begin
            total_reg <= tot[31:0];
            over_reg  <= over_reg | tot[32];
        end
        if (cmd.emit)
        begin
            if (cmd.len_mode)
            begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= '0;
                arc_reg   <= over_reg ? 32'hFFFF_FFFF : total_reg;
            end
            else
            begin
                pos_x_reg <= cur_reg[0];
                pos_y_reg <= cur_reg[1];
                pos_z_reg <= cur_reg[2];
                arc_reg   <= '0;
            end
        end
    end

    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;
    assign pos_z      = pos_z_reg;
    assign arc_length = arc_reg;

endmodule

@@ rtl/cubic_bezier_arc_length_top.sv @@
// Top level of the cubic Bezier evaluator and chord-length block.
// Depends on cbal_pkg, cbal_if, cbal_ctrl and cbal_datapath.
//
// A load request stores one control point and gives no response.
// An evaluate request sets up the three coefficients, then runs each axis in turn
// through the shared Horner multiplier. A length request evaluates each of the
// SEGMENTS + 1 curve samples the same way, and each chord adds the squaring of the
// three axis differences, the 32-step bit-pair square root, the root setup and the
// chord addition. One request is worked on at a time; a new request is taken once
// the previous response is in the output register.
module cubic_bezier_arc_length_top
    import cbal_pkg::*;
#(
    parameter int unsigned SEGMENTS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    cbal_req_if.sink    req,
    cbal_rsp_if.source  rsp
);

    cbal_cmd_t cmd;

    cbal_ctrl #(
        .SEGMENTS (SEGMENTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .op        (req.op),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    cbal_datapath #(
        .SEGMENTS (SEGMENTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .point_index (req.point_index),
        .coord_x     (req.coord_x),
        .coord_y     (req.coord_y),
        .coord_z     (req.coord_z),
        .curve_param (req.curve_param),
        .pos_x       (rsp.pos_x),
        .pos_y       (rsp.pos_y),
        .pos_z       (rsp.pos_z),
        .arc_length  (rsp.arc_length)
    );

endmodule

@@ tb/cbal_checker.sv @@
`timescale 1ns / 1ps
// Checker for the cubic Bezier block: watches both channels, predicts responses.
// Depends on cbal_pkg and the interfaces in cbal_if.sv.
module cbal_checker
    import cbal_pkg::*;
#(
    parameter int unsigned SEGMENTS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    cbal_req_if        req,
    cbal_rsp_if        rsp,
    output int         fail_count,
    output int         pending,
    output int         eval_seen,
    output int         len_seen
);

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [31:0]        len;
    } bezier_result_t;

    logic [31:0]    ctrl_pts [12];
    bezier_result_t expected_q [$];

    function automatic longint q16_round(longint p);
        longint x;
        x = p + 32768;
        if (x >= 0)
            return x / 65536;
        return -((-x + 65535) / 65536);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint curve_axis(int axis, longint t);
        longint p0, p1, p2, p3, c, b, a, h;
        p0 = longint'($signed(ctrl_pts[axis]));
        p1 = longint'($signed(ctrl_pts[3 + axis]));
        p2 = longint'($signed(ctrl_pts[6 + axis]));
        p3 = longint'($signed(ctrl_pts[9 + axis]));
        c = 3 * (p1 - p0);
        b = 3 * (p2 - p1) - c;
        a = p3 - p0 - c - b;
        h = q16_round(a * t) + b;
        h = q16_round(h * t) + c;
        h = q16_round(h * t) + p0;
        return clamp32(h);
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] chord_length();
        longint      prev [3];
        longint      cur, d, t, k;
        logic [63:0] sq, s, m, total;
        logic        over;
        for (int ax = 0; ax < 3; ax++)
            prev[ax] = curve_axis(ax, 0);
        total = 0;
        for (k = 1; k <= SEGMENTS; k++)
        begin
            t = (k * 65536 + SEGMENTS / 2) / SEGMENTS;
            sq = 0;
            over = 1'b0;
            for (int ax = 0; ax < 3; ax++)
            begin
                cur = curve_axis(ax, t);
                d = cur - prev[ax];
                m = (d < 0) ? -d : d;
                s = m * m;
                if (sq + s < sq)
                    over = 1'b1;
                sq = sq + s;
                prev[ax] = cur;
            end
            if (over)
                return 32'hFFFF_FFFF;
            total = total + floor_sqrt(sq);
            if (total > 64'hFFFF_FFFF)
                return 32'hFFFF_FFFF;
        end
        return total[31:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bezier_result_t e, got;
        longint         t;
        if (!rst_n)
        begin
            for (int i = 0; i < 12; i++)
                ctrl_pts[i] <= '0;
            expected_q.delete();
            fail_count <= 0;
            pending <= 0;
            eval_seen <= 0;
            len_seen <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.px = rsp.pos_x;
                got.py = rsp.pos_y;
                got.pz = rsp.pos_z;
                got.len = rsp.arc_length;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected response x=%h y=%h z=%h len=%h", $time,
                             got.px, got.py, got.pz, got.len);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (got.px !== e.px || got.py !== e.py || got.pz !== e.pz
                        || got.len !== e.len)
                    begin
                        $display("%0t: mismatch expected x=%h y=%h z=%h len=%h", $time,
                                 e.px, e.py, e.pz, e.len);
                        $display("%0t:          actual   x=%h y=%h z=%h len=%h", $time,
                                 got.px, got.py, got.pz, got.len);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                case (cbal_op_t'(req.op))
                    OP_LOAD:
                    begin
                        ctrl_pts[req.point_index * 3]     <= req.coord_x;
                        ctrl_pts[req.point_index * 3 + 1] <= req.coord_y;
                        ctrl_pts[req.point_index * 3 + 2] <= req.coord_z;
                    end
                    OP_EVAL:
                    begin
                        t = (req.curve_param > ONE_Q16) ? ONE_Q16 : req.curve_param;
                        e.px = curve_axis(0, t);
                        e.py = curve_axis(1, t);
                        e.pz = curve_axis(2, t);
                        e.len = '0;
                        expected_q.push_back(e);
                        eval_seen <= eval_seen + 1;
                    end
                    OP_LEN:
                    begin
                        e.px = '0;
                        e.py = '0;
                        e.pz = '0;
                        e.len = chord_length();
                        expected_q.push_back(e);
                        len_seen <= len_seen + 1;
                    end
                    default: ;
                endcase
            end
            pending <= expected_q.size();
        end
    end

endmodule

@@ tb/tb_cubic_bezier_arc_length_top.sv @@
`timescale 1ns / 1ps
// Testbench top for cubic_bezier_arc_length_top: clock, reset, requests, verdict.
// Depends on cbal_pkg, cbal_if, the block and cbal_checker.
module tb_cubic_bezier_arc_length_top;
    import cbal_pkg::*;

    localparam int unsigned SEGMENTS = 32;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count, pending, eval_seen, len_seen;
    logic calm = 1'b0;
    logic hold_rsp = 1'b0;

    cbal_req_if req ();
    cbal_rsp_if rsp ();

    always #5 clk = ~clk;

    cubic_bezier_arc_length_top #(.SEGMENTS(SEGMENTS)) DUT (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source));

    cbal_checker #(.SEGMENTS(SEGMENTS)) checker_i (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .fail_count(fail_count),
        .pending(pending), .eval_seen(eval_seen), .len_seen(len_seen));

    initial
    begin
        req.valid = 1'b0;
        req.op = OP_LOAD;
        req.point_index = '0;
        req.coord_x = '0;
        req.coord_y = '0;
        req.coord_z = '0;
        req.curve_param = '0;
        rsp.ready = 1'b0;
    end

    // Response side: random stall bursts, one long hold-off, none at the end.
    initial
    begin
        int   n;
        logic held_off;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rsp && !held_off)
            begin
                // One long hold-off, counted here, so the block fills and stalls requests.
                held_off = 1'b1;
                rsp.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 1'b0;
                n = $urandom_range(1, 19);
                repeat (n - 1) @(posedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    task automatic send(cbal_op_t op, logic [1:0] idx, logic [31:0] x, logic [31:0] y,
                        logic [31:0] z, logic [16:0] t);
        int n;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req.valid <= 1'b0;
            n = $urandom_range(1, 19);
            repeat (n) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op <= op;
        req.point_index <= idx;
        req.coord_x <= x;
        req.coord_y <= y;
        req.coord_z <= z;
        req.curve_param <= t;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
        endcase
    endfunction

    task automatic load_curve();
        for (int p = 0; p < 4; p++)
            send(OP_LOAD, p[1:0], rand_coord(), rand_coord(), rand_coord(), 17'($urandom));
    endtask

    initial
    begin
        int r;
        @(posedge clk);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset curve, extremes, clamped parameter, unknown op.
        send(OP_EVAL, 2'd0, '0, '0, '0, 17'd32768);
        send(OP_LEN, 2'd0, '0, '0, '0, '0);
        send(OP_LOAD, 2'd0, 32'h8000_0000, 32'h7FFF_FFFF, '0, 17'h1FFFF);
        send(OP_LOAD, 2'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, '0);
        send(OP_LOAD, 2'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, '0);
        send(OP_LOAD, 2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, '0);
        send(OP_EVAL, 2'd3, '1, '1, '1, 17'd0);
        send(OP_EVAL, 2'd0, '0, '0, '0, 17'd65536);
        send(OP_EVAL, 2'd0, '0, '0, '0, 17'h1FFFF);
        send(OP_EVAL, 2'd0, '0, '0, '0, 17'd65535);
        send(OP_EVAL, 2'd0, '0, '0, '0, 17'd1);
        send(OP_LEN, 2'd1, '1, '1, '1, '1);
        send(OP_NONE, 2'd2, '1, '1, '1, '1);
        send(OP_LOAD, 2'd1, 32'h0001_0000, 32'h0002_0000, '0, '0);
        send(OP_LOAD, 2'd2, 32'h0003_0000, '0, 32'hFFFE_0000, '0);
        send(OP_LEN, 2'd0, '0, '0, '0, '0);
        send(OP_EVAL, 2'd0, '0, '0, '0, 17'd16384);

        // Long response hold-off while requests keep coming.
        hold_rsp <= 1'b1;
        for (int i = 0; i < 6; i++)
            send(OP_EVAL, 2'd0, '0, '0, '0, 17'($urandom_range(0, 65536)));

        for (int i = 0; i < 400; i++)
        begin
            if (i == 350)
                calm <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 8)
                load_curve();
            else if (r < 18)
                send(OP_LOAD, 2'($urandom), rand_coord(), rand_coord(), rand_coord(),
                     17'($urandom));
            else if (r < 28)
                send(OP_LEN, 2'($urandom), $urandom, $urandom, $urandom, 17'($urandom));
            else if (r < 32)
                send(OP_NONE, 2'($urandom), $urandom, $urandom, $urandom, 17'($urandom));
            else
                send(OP_EVAL, 2'($urandom), $urandom, $urandom, $urandom,
                     $urandom_range(0, 3) == 0 ? 17'($urandom) :
                     17'($urandom_range(0, 65536)));
        end
        req.valid <= 1'b0;
        // Let the checker count the last accepted request before waiting on it.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Covered %0d evaluate and %0d length responses over random curves,",
                 eval_seen, len_seen);
        $display("with extreme coordinates, clamped parameters and stalls on both sides.");
        if (fail_count == 0)
            $display("PASS cubic_bezier_arc_length_top");
        else
            $display("FAIL cubic_bezier_arc_length_top");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("FAIL cubic_bezier_arc_length_top");
        $finish;
    end

endmodule
